### rtl/core/vfp_pkg.sv
// vision frame parser package: frame constants, register indexes, shared types
// no dependencies

package vfp_pkg;

    localparam int unsigned FRAME_BYTES = 13;
    localparam int unsigned CNT_W       = $clog2(FRAME_BYTES + 2);
    localparam int unsigned STORE_FIRST = 1;
    localparam int unsigned STORE_LAST  = 11;

    localparam logic [7:0] HEADER_BYTE  = 8'h5A;
    localparam logic [7:0] TRAILER_BYTE = 8'hA5;

    localparam int unsigned REG_IDX_W  = 8;
    localparam int unsigned REG_DATA_W = 16;

    localparam logic [REG_IDX_W-1:0] REG_DISTANCE_LIMIT = 8'd0;
    localparam logic [REG_IDX_W-1:0] REG_TARGET_X_LIMIT = 8'd1;
    localparam logic [REG_IDX_W-1:0] REG_TARGET_Y_LIMIT = 8'd2;
    localparam logic [REG_IDX_W-1:0] REG_SPEED_BOUND    = 8'd3;

    localparam logic [15:0] DISTANCE_LIMIT_RST = 16'd1000;
    localparam logic [15:0] TARGET_X_LIMIT_RST = 16'd2000;
    localparam logic [15:0] TARGET_Y_LIMIT_RST = 16'd1500;
    localparam logic [14:0] SPEED_BOUND_RST    = 15'd1900;

    typedef struct packed {
        logic [15:0] distance_limit;
        logic [15:0] target_x_limit;
        logic [15:0] target_y_limit;
        logic [14:0] speed_bound;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  status;
        logic [15:0] distance;
        logic [15:0] target_x;
        logic [15:0] target_y;
        logic [15:0] speed_raw;
        logic [7:0]  predict_time;
        logic [7:0]  processing_time;
    } t_frame;

endpackage

### rtl/core/vfp_if.sv
// vision frame parser channel interfaces: byte input, decoded result, register writes
// depends on vfp_pkg

interface vfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface vfp_result_if;
    logic        valid;
    logic        ready;
    logic        armor_seen;
    logic [2:0]  armor_kind;
    logic [15:0] distance;
    logic [19:0] distance_smoothed;
    logic [15:0] target_x;
    logic [15:0] target_y;
    logic signed [15:0] pixel_speed;
    logic [7:0]  predict_time;
    logic [7:0]  processing_time;

    modport source (output valid, input ready, output armor_seen, output armor_kind,
                    output distance, output distance_smoothed, output target_x,
                    output target_y, output pixel_speed, output predict_time,
                    output processing_time);
    modport sink   (input valid, output ready, input armor_seen, input armor_kind,
                    input distance, input distance_smoothed, input target_x,
                    input target_y, input pixel_speed, input predict_time,
                    input processing_time);
endinterface

interface vfp_cfg_if import vfp_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [REG_IDX_W-1:0]  reg_index;
    logic [REG_DATA_W-1:0] reg_data;

    modport source (output valid, output reg_index, output reg_data, input ready);
    modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

### rtl/core/vfp_cfg_regs.sv
// vision frame parser configuration registers: limits and speed bound
// depends on vfp_pkg and vfp_cfg_if

module vfp_cfg_regs import vfp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vfp_cfg_if.sink   i_cfg,
    output t_cfg      o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.reg_index)
                REG_DISTANCE_LIMIT: n_cfg.distance_limit = i_cfg.reg_data;
                REG_TARGET_X_LIMIT: n_cfg.target_x_limit = i_cfg.reg_data;
                REG_TARGET_Y_LIMIT: n_cfg.target_y_limit = i_cfg.reg_data;
                REG_SPEED_BOUND:    n_cfg.speed_bound    = i_cfg.reg_data[14:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.distance_limit <= DISTANCE_LIMIT_RST;
            r_cfg.target_x_limit <= TARGET_X_LIMIT_RST;
            r_cfg.target_y_limit <= TARGET_Y_LIMIT_RST;
            r_cfg.speed_bound    <= SPEED_BOUND_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

### rtl/core/vfp_framer.sv
// vision frame parser byte framer: header hunt, byte store, frame completion
// depends on vfp_pkg and vfp_byte_if; hands complete frames to the decoder

module vfp_framer import vfp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vfp_byte_if.sink  i_rx,
    input  logic      i_take,
    output logic      o_frame_valid,
    output t_frame    o_frame
);

    logic             r_in_frame;
    logic [CNT_W-1:0] r_count;
    logic [7:0]       r_store [STORE_FIRST:STORE_LAST];
    logic             r_dec_valid;
    t_frame           r_frame;

    logic             n_in_frame;
    logic [CNT_W-1:0] n_count;
    logic             n_dec_valid;

    logic             accept;
    logic             in_eff;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] cnt_next;
    logic             is_trailer;
    logic             done;
    logic             drop;

    assign i_rx.ready    = !r_dec_valid || i_take;
    assign accept        = i_rx.valid && i_rx.ready;
    assign o_frame_valid = r_dec_valid;
    assign o_frame       = r_frame;

    assign in_eff     = r_in_frame || (i_rx.rx_byte == HEADER_BYTE);
    assign cnt        = r_in_frame ? r_count : '0;
    assign cnt_next   = cnt + CNT_W'(1);
    assign is_trailer = i_rx.rx_byte == TRAILER_BYTE;
    assign done       = in_eff && is_trailer && (cnt_next == CNT_W'(FRAME_BYTES));
    assign drop       = in_eff && ((is_trailer && (cnt_next != CNT_W'(FRAME_BYTES)))
                                   || (cnt_next > CNT_W'(FRAME_BYTES)));

    always_comb begin
        n_in_frame  = r_in_frame;
        n_count     = r_count;
        n_dec_valid = r_dec_valid && !i_take;
        if (accept) begin
            if (!in_eff || done || drop) begin
                n_in_frame = 1'b0;
                n_count    = '0;
            end else begin
                n_in_frame = 1'b1;
                n_count    = cnt_next;
            end
            if (done) begin
                n_dec_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame  <= 1'b0;
            r_count     <= '0;
            r_dec_valid <= 1'b0;
        end else begin
            r_in_frame  <= n_in_frame;
            r_count     <= n_count;
            r_dec_valid <= n_dec_valid;
        end
    end

    // payload store, only the bytes the decode reads
    always_ff @(posedge i_clk) begin
        for (int k = STORE_FIRST; k <= STORE_LAST; k++) begin
            if (accept && in_eff && (cnt == CNT_W'(k))) begin
                r_store[k] <= i_rx.rx_byte;
            end
        end
        if (accept && done) begin
            r_frame.status          <= r_store[1];
            r_frame.distance        <= {r_store[2], r_store[3]};
            r_frame.target_x        <= {r_store[4], r_store[5]};
            r_frame.target_y        <= {r_store[6], r_store[7]};
            r_frame.speed_raw       <= {r_store[8], r_store[9]};
            r_frame.predict_time    <= r_store[10];
            r_frame.processing_time <= r_store[11];
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FRAME_BYTES))
        else $error("frame byte count out of range");

    a_idle_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_frame |-> (r_count == '0))
        else $error("byte count nonzero outside a frame");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && done) |=> (r_dec_valid && !r_in_frame))
        else $error("completed frame not handed to decoder");

    a_dec_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dec_valid && !i_take) |=> (r_dec_valid && $stable(r_frame)))
        else $error("pending frame lost while decoder busy");

endmodule

### rtl/core/vfp_decode.sv
// vision frame parser decode stage: limit checks, distance filter, speed clamp
// depends on vfp_pkg and vfp_result_if; owns the held values and the result register

module vfp_decode import vfp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_frame_valid,
    input  t_frame      i_frame,
    output logic        o_take,
    vfp_result_if.source o_res
);

    logic        r_out_valid;
    logic [15:0] r_distance;
    logic [19:0] r_smoothed;
    logic [15:0] r_target_x;
    logic [15:0] r_target_y;
    logic        r_armor_seen;
    logic [2:0]  r_armor_kind;
    logic signed [15:0] r_speed;
    logic [7:0]  r_predict_time;
    logic [7:0]  r_processing_time;

    logic        load;
    logic        dist_ok;
    logic [20:0] smooth_sum;
    logic signed [15:0] speed_in;
    logic signed [15:0] bound_pos;
    logic signed [15:0] bound_neg;
    logic signed [15:0] speed_clamped;

    assign o_take = !r_out_valid || o_res.ready;
    assign load   = o_take && i_frame_valid;

    assign dist_ok    = i_frame.distance <= i_cfg.distance_limit;
    assign smooth_sum = {1'b0, r_smoothed} + {1'b0, i_frame.distance, 4'b0000};

    assign speed_in  = i_frame.speed_raw;
    assign bound_pos = {1'b0, i_cfg.speed_bound};
    assign bound_neg = -bound_pos;

    always_comb begin
        if (speed_in > bound_pos) begin
            speed_clamped = bound_pos;
        end else if (speed_in < bound_neg) begin
            speed_clamped = bound_neg;
        end else begin
            speed_clamped = speed_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_distance  <= '0;
            r_smoothed  <= '0;
            r_target_x  <= '0;
            r_target_y  <= '0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                if (dist_ok) begin
                    r_distance <= i_frame.distance;
                    r_smoothed <= smooth_sum[20:1];
                end
                if (i_frame.target_x < i_cfg.target_x_limit) begin
                    r_target_x <= i_frame.target_x;
                end
                if (i_frame.target_y < i_cfg.target_y_limit) begin
                    r_target_y <= i_frame.target_y;
                end
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_armor_seen      <= i_frame.status[7];
            r_armor_kind      <= i_frame.status[6:4];
            r_speed           <= speed_clamped;
            r_predict_time    <= i_frame.predict_time;
            r_processing_time <= i_frame.processing_time;
        end
    end

    assign o_res.valid             = r_out_valid;
    assign o_res.armor_seen        = r_armor_seen;
    assign o_res.armor_kind        = r_armor_kind;
    assign o_res.distance          = r_distance;
    assign o_res.distance_smoothed = r_smoothed;
    assign o_res.target_x          = r_target_x;
    assign o_res.target_y          = r_target_y;
    assign o_res.pixel_speed       = r_speed;
    assign o_res.predict_time      = r_predict_time;
    assign o_res.processing_time   = r_processing_time;

    a_speed_in_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> ((speed_clamped <= bound_pos) && (speed_clamped >= bound_neg)))
        else $error("clamped speed outside bound");

    a_take_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_take)
        else $error("empty result register refuses a frame");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> r_out_valid)
        else $error("decoded frame not presented");

endmodule

### rtl/core/vision_frame_parser_core.sv
// vision frame parser top level: framer, decode stage and configuration registers
// depends on vfp_pkg, vfp_if, vfp_cfg_regs, vfp_framer, vfp_decode
//
// usage
//   i_rx carries one received link byte per item. outside a frame bytes are
//   dropped until header 0x5A; 13 bytes ending in trailer 0xA5 form a frame.
//   an early 0xA5 or a 14th byte drops the frame without a result.
//   o_res carries one decoded item per completed frame; every other byte
//   gives no result.
//   i_cfg writes the limit registers by index; it is always ready and is
//   meant to be written only while no frame is in flight.
// timing
//   one byte per cycle sustained while i_rx.ready is high. the trailer byte
//   taken loads the frame snapshot register; the decode stage then loads the
//   result register, which presents the decoded item.
// reset
//   synchronous active-low reset returns to header hunt, clears the held
//   distance, filter and target values and reloads the default limits.
// stall
//   a stalled result holds; the snapshot register still takes one more frame,
//   and i_rx.ready drops only while both are full.

module vision_frame_parser_core import vfp_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    vfp_byte_if.sink     i_rx,
    vfp_cfg_if.sink      i_cfg,
    vfp_result_if.source o_res
);

    t_cfg   cfg;
    logic   take;
    logic   frame_valid;
    t_frame frame;

    vfp_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    vfp_framer u_framer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx          (i_rx),
        .i_take        (take),
        .o_frame_valid (frame_valid),
        .o_frame       (frame)
    );

    vfp_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_frame_valid (frame_valid),
        .i_frame       (frame),
        .o_take        (take),
        .o_res         (o_res)
    );

endmodule
